>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the segment intersection test unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition now implies a condition in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition now implies a condition in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// shared constants and types of the segment intersection test unit
// ----------------------------------------------------------------------------
package sit_pkg;

  // default coordinate width
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // stage load enables handed to the cross-product lanes
  typedef struct packed {
    logic en2;  // product stage loads
    logic en3;  // compare stage loads
  } sit_ctl_t;

endpackage

>>> src/sit_cross.sv
// ----------------------------------------------------------------------------
// sit_cross
// one cross-product sign lane: registered products, then registered compare
// ----------------------------------------------------------------------------
module sit_cross #(
  parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  sit_pkg::sit_ctl_t           ctl,
  input  logic signed [COORD_WIDTH:0] l_a,
  input  logic signed [COORD_WIDTH:0] l_b,
  input  logic signed [COORD_WIDTH:0] r_a,
  input  logic signed [COORD_WIDTH:0] r_b,
  output logic                        pos,
  output logic                        neg
);
  import sit_pkg::*;

  localparam int unsigned PW = 2 * (COORD_WIDTH + 1);

  logic signed [PW-1:0] l_r, l_nxt;
  logic signed [PW-1:0] r_r, r_nxt;
  logic                 pos_r, pos_nxt;
  logic                 neg_r, neg_nxt;

  always_comb begin
    l_nxt   = PW'(l_a) * PW'(l_b);
    r_nxt   = PW'(r_a) * PW'(r_b);
    pos_nxt = (l_r > r_r);
    neg_nxt = (l_r < r_r);
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      l_r <= l_nxt;
      r_r <= r_nxt;
    end
    if (ctl.en3) begin
      pos_r <= pos_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign pos = pos_r;
  assign neg = neg_r;

endmodule

>>> src/segment_intersection_test_unit.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_unit
// streaming test of whether two line segments intersect
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries segment AB and segment CD as
//   signed coordinates; a transfer happens when both are high at a clock edge
//   result channel out_valid/out_ready carries out_intersects, one result per
//   input transfer, in order
//   pipeline: four register stages (differences and box tests, products,
//   product compare, sign combine); a pair passes through them in that
//   order, and out_valid rises once it reaches the sign combine register
//   throughput: one pair per cycle while out_ready is high; every stage,
//   including the multipliers, takes a new pair each cycle it is free to load
//   stall: with out_ready low the pipeline fills and holds, up to four pairs
//   in flight; in_ready drops only when every stage is occupied
//   reset: rst_n low empties the pipeline; no results are pending afterwards
//   shared endpoints and disjoint bounding boxes give 0; otherwise the four
//   cross-product signs decide, touching and collinear overlap give 1
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_test_unit #(
  parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_d_x,
  input  logic signed [COORD_WIDTH-1:0] in_d_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_intersects
);
  import sit_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;

  typedef logic signed [DW-1:0] diff_t;

  // stage valids and load enables
  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, v4_r, v4_nxt;
  logic en1, en2, en3, en4;
  sit_ctl_t ctl;

  // stage 1 payload: coordinate differences and the early-reject flag
  diff_t cax_r, bay_r, bax_r, cay_r, dax_r, day_r;
  diff_t acx_r, dcy_r, dcx_r, acy_r, bcx_r, bcy_r;
  diff_t cax_nxt, bay_nxt, bax_nxt, cay_nxt, dax_nxt, day_nxt;
  diff_t acx_nxt, dcy_nxt, dcx_nxt, acy_nxt, bcx_nxt, bcy_nxt;
  logic  rej1_r, rej1_nxt, rej2_r, rej3_r;

  logic share_ep, box_ok;
  logic su_p, su_n, sv_p, sv_n, sw_p, sw_n, sz_p, sz_n;
  logic hit_nxt, hit_r;

  // sign-extended difference of two coordinates, never overflows
  function automatic diff_t dif(input logic signed [COORD_WIDTH-1:0] p,
                                input logic signed [COORD_WIDTH-1:0] q);
    diff_t pe;
    diff_t qe;
    pe  = DW'(p);
    qe  = DW'(q);
    dif = pe - qe;
  endfunction

  // elastic pipeline: a stage loads when empty or when it moves on
  always_comb begin
    en4      = !v4_r || out_ready;
    en3      = !v3_r || en4;
    en2      = !v2_r || en3;
    en1      = !v1_r || en2;
    in_ready = en1;
    ctl.en2  = en2;
    ctl.en3  = en3;
    v1_nxt   = en1 ? in_valid : v1_r;
    v2_nxt   = en2 ? v1_r : v2_r;
    v3_nxt   = en3 ? v2_r : v3_r;
    v4_nxt   = en4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // stage 1: endpoint equality, box overlap, differences
  always_comb begin
    share_ep = (in_a_x == in_c_x && in_a_y == in_c_y) ||
               (in_a_x == in_d_x && in_a_y == in_d_y) ||
               (in_b_x == in_c_x && in_b_y == in_c_y) ||
               (in_b_x == in_d_x && in_b_y == in_d_y);
    // min(p,q) <= max(r,s) is true when any of the four pairs is ordered
    box_ok = (in_a_x <= in_c_x || in_a_x <= in_d_x ||
              in_b_x <= in_c_x || in_b_x <= in_d_x) &&
             (in_c_y <= in_a_y || in_c_y <= in_b_y ||
              in_d_y <= in_a_y || in_d_y <= in_b_y) &&
             (in_c_x <= in_a_x || in_c_x <= in_b_x ||
              in_d_x <= in_a_x || in_d_x <= in_b_x) &&
             (in_a_y <= in_c_y || in_a_y <= in_d_y ||
              in_b_y <= in_c_y || in_b_y <= in_d_y);
    rej1_nxt = share_ep || !box_ok;
    cax_nxt  = dif(in_c_x, in_a_x);
    bay_nxt  = dif(in_b_y, in_a_y);
    bax_nxt  = dif(in_b_x, in_a_x);
    cay_nxt  = dif(in_c_y, in_a_y);
    dax_nxt  = dif(in_d_x, in_a_x);
    day_nxt  = dif(in_d_y, in_a_y);
    acx_nxt  = dif(in_a_x, in_c_x);
    dcy_nxt  = dif(in_d_y, in_c_y);
    dcx_nxt  = dif(in_d_x, in_c_x);
    acy_nxt  = dif(in_a_y, in_c_y);
    bcx_nxt  = dif(in_b_x, in_c_x);
    bcy_nxt  = dif(in_b_y, in_c_y);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      rej1_r <= rej1_nxt;
      cax_r  <= cax_nxt;
      bay_r  <= bay_nxt;
      bax_r  <= bax_nxt;
      cay_r  <= cay_nxt;
      dax_r  <= dax_nxt;
      day_r  <= day_nxt;
      acx_r  <= acx_nxt;
      dcy_r  <= dcy_nxt;
      dcx_r  <= dcx_nxt;
      acy_r  <= acy_nxt;
      bcx_r  <= bcx_nxt;
      bcy_r  <= bcy_nxt;
    end
    if (en2) begin
      rej2_r <= rej1_r;
    end
    if (en3) begin
      rej3_r <= rej2_r;
    end
    if (en4) begin
      hit_r <= hit_nxt;
    end
  end

  // stages 2 and 3: the four cross-product sign lanes
  // u = (C-A) x (B-A)
  sit_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_u (
    .clk(clk), .ctl(ctl),
    .l_a(cax_r), .l_b(bay_r), .r_a(bax_r), .r_b(cay_r),
    .pos(su_p), .neg(su_n)
  );

  // v = (D-A) x (B-A)
  sit_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_v (
    .clk(clk), .ctl(ctl),
    .l_a(dax_r), .l_b(bay_r), .r_a(bax_r), .r_b(day_r),
    .pos(sv_p), .neg(sv_n)
  );

  // w = (A-C) x (D-C)
  sit_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_w (
    .clk(clk), .ctl(ctl),
    .l_a(acx_r), .l_b(dcy_r), .r_a(dcx_r), .r_b(acy_r),
    .pos(sw_p), .neg(sw_n)
  );

  // z = (B-C) x (D-C)
  sit_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_z (
    .clk(clk), .ctl(ctl),
    .l_a(bcx_r), .l_b(dcy_r), .r_a(dcx_r), .r_b(bcy_r),
    .pos(sz_p), .neg(sz_n)
  );

  // stage 4: straddle tests, a pair fails only on equal strict signs
  always_comb begin
    hit_nxt = !rej3_r &&
              !((su_p && sv_p) || (su_n && sv_n)) &&
              !((sw_p && sz_p) || (sw_n && sz_n));
  end

  assign out_valid      = v4_r;
  assign out_intersects = hit_r;

  // a full pipeline is the only reason to refuse a transfer
  `ASSERT_SAME(a_full_when_blocked, clk, rst_n, !in_ready, v1_r && v2_r && v3_r && v4_r)
  // an item moving out of stage one lands in stage two
  `ASSERT_NEXT(a_stage2_load, clk, rst_n, v1_r && en2, v2_r)
  // a held compare stage keeps its item
  `ASSERT_NEXT(a_stage3_hold, clk, rst_n, v3_r && !en4, v3_r)
  // rejected pairs always report no intersection
  `ASSERT_NEXT(a_reject_zero, clk, rst_n, v3_r && en4 && rej3_r, !out_intersects)

endmodule
